FILE: rtl/core/ptrc_pkg.sv
`timescale 1ns / 1ps
package ptrc_pkg;

  localparam int CAPACITY   = 1024;
  localparam int DIMS       = 2;
  localparam int COORD_BITS = 16;

  localparam int ADDR_W  = $clog2(CAPACITY);
  localparam int HELD_W  = $clog2(CAPACITY + 1);
  localparam int IDX_W   = 10;
  localparam int IN_W    = 16;
  localparam int PER_W   = 16;
  localparam int DIST_W  = 34;
  localparam int CNT_W   = 11;
  localparam int PT_W    = DIMS * COORD_BITS;

  // Signed width for one axis difference and its wrapped alternative.
  localparam int DIFF_W  = ((COORD_BITS > PER_W) ? COORD_BITS : PER_W) + 2;
  localparam int MAG_W   = DIFF_W - 1;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int ACC_W   = ((SQ_W > DIST_W) ? SQ_W : DIST_W) + 1;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [DIMS-1:0][COORD_BITS-1:0] point_t;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_DROP   = 3'd1,
    OP_MOVE   = 3'd2,
    OP_MSAVE  = 3'd3,
    OP_UNDO   = 3'd4,
    OP_REMOVE = 3'd5,
    OP_COUNT  = 3'd6,
    OP_DIST   = 3'd7
  } mode_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_BAD   = 2'd3;

  localparam logic [1:0] CFG_TOROIDAL = 2'd0;
  localparam logic [1:0] CFG_PERIOD_X = 2'd1;
  localparam logic [1:0] CFG_PERIOD_Y = 2'd2;
  localparam logic [1:0] CFG_PERIOD_Z = 2'd3;

  // One point travelling along the distance chain with its running sum.
  typedef struct packed {
    logic              vld;
    logic              cnt;
    logic              last;
    logic [DIST_W-1:0] sum;
    point_t            pt;
  } link_t;

endpackage

FILE: rtl/core/ptrc_in_if.sv
`timescale 1ns / 1ps
interface ptrc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [9:0]  index_a;
  logic [9:0]  index_b;
  logic [15:0] coord_x;
  logic [15:0] coord_y;
  logic [15:0] coord_z;
  logic [33:0] radius_sq;

  modport source (output valid, mode, index_a, index_b, coord_x, coord_y, coord_z,
                  radius_sq, input ready);
  modport sink (input valid, mode, index_a, index_b, coord_x, coord_y, coord_z,
                radius_sq, output ready);
endinterface

FILE: rtl/core/ptrc_out_if.sv
`timescale 1ns / 1ps
interface ptrc_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] neighbour_count;
  logic [33:0] dist_sq;
  logic [10:0] point_count;
  logic [1:0]  status;

  modport source (output valid, neighbour_count, dist_sq, point_count, status,
                  input ready);
  modport sink (input valid, neighbour_count, dist_sq, point_count, status,
                output ready);
endinterface

FILE: rtl/core/ptrc_ram.sv
`timescale 1ns / 1ps
module ptrc_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/ptrc_cell.sv
`timescale 1ns / 1ps
module ptrc_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    toroidal,
  input  logic [15:0]             period,
  input  ptrc_pkg::coord_t        centre,
  input  ptrc_pkg::link_t         lk_in,
  output ptrc_pkg::link_t         lk_out
);
  import ptrc_pkg::*;

  logic signed [DIFF_W-1:0] p_s;
  logic signed [DIFF_W-1:0] q_s;
  logic signed [DIFF_W-1:0] d_s;
  logic signed [DIFF_W-1:0] alt_s;
  logic signed [DIFF_W-1:0] w_s;
  logic [MAG_W-1:0]         mag_next;
  logic [MAG_W-1:0]         mag;
  link_t                    mid;
  logic [SQ_W-1:0]          sq;
  logic [ACC_W-1:0]         acc;

  // Axis difference, optionally wrapped by the period, then its magnitude.
  always_comb begin
    p_s   = signed'(DIFF_W'(lk_in.pt[0]));
    q_s   = signed'(DIFF_W'(centre));
    d_s   = (p_s > q_s) ? (p_s - q_s) : (q_s - p_s);
    alt_s = signed'(DIFF_W'(period)) - d_s;
    w_s   = (toroidal && (alt_s < d_s)) ? alt_s : d_s;
    mag_next = (w_s < 0) ? MAG_W'(-w_s) : MAG_W'(w_s);
  end

  // Square and saturating accumulate.
  always_comb begin
    sq  = SQ_W'(mag) * SQ_W'(mag);
    acc = ACC_W'(mid.sum) + ACC_W'(sq);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid.vld    <= 1'b0;
      lk_out.vld <= 1'b0;
    end else begin
      mid.vld    <= lk_in.vld;
      lk_out.vld <= mid.vld;
    end
    mid.cnt  <= lk_in.cnt;
    mid.last <= lk_in.last;
    mid.sum  <= lk_in.sum;
    mid.pt   <= lk_in.pt >> COORD_BITS;
    mag      <= mag_next;
    lk_out.cnt  <= mid.cnt;
    lk_out.last <= mid.last;
    lk_out.pt   <= mid.pt;
    lk_out.sum  <= (acc > ACC_W'(DIST_MAX)) ? DIST_MAX : acc[DIST_W-1:0];
  end

endmodule

FILE: rtl/core/point_table_radius_neighbour_count_core.sv
`timescale 1ns / 1ps
// Point table with fixed-radius neighbour count.
// Commands arrive on in_ch (valid/ready); one result per command leaves on out_ch.
// The user writes registers (toroidal, period_x, period_y, period_z) via cfg_we,
// cfg_index, cfg_data only when no command is in flight; not enforced by the block.
// Points live in a single-port-write, registered-read RAM. Distances are formed by
// a chain of one cell per axis; each cell registers its axis magnitude, then adds
// its axis square to the running sum. Count and remove walk the table through the
// one RAM read port, one point per cycle.
// One command is worked on at a time; a new command is taken while the previous
// result waits in the output register.
// Reset empties the table, clears the saved move and sets the registers to their
// defaults; the RAM itself is not cleared (entries are written before they are read).
// A stalled receiver holds the result; a finished command then waits until the
// output register is free.
module point_table_radius_neighbour_count_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  ptrc_in_if.sink     in_ch,
  ptrc_out_if.source  out_ch
);
  import ptrc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SAVE, S_SHIFT, S_LOADC, S_STREAM, S_DRAIN, S_DONE
  } state_t;

  state_t              state;
  mode_t               op;
  logic [IDX_W-1:0]    ia;
  logic [IDX_W-1:0]    ib;
  point_t              pt_r;
  logic [DIST_W-1:0]   rsq;
  logic [1:0]          stat;
  logic [HELD_W-1:0]   ptr;
  logic [ADDR_W-1:0]   wp;
  logic                pend;
  logic                cpend;
  logic                feed_vld;
  logic                feed_cnt;
  logic                feed_last;
  point_t              centre;
  logic [CNT_W-1:0]    count;
  logic [DIST_W-1:0]   dist_val;
  logic [HELD_W-1:0]   held;
  logic [IDX_W-1:0]    saved_idx;
  point_t              saved_pt;
  logic                saved_vld;
  logic                toroidal;
  logic [PER_W-1:0]    period [3];

  mode_t               in_mode;
  point_t              in_pt;
  logic                accept;
  logic [1:0]          stat_next;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  point_t              ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  point_t              ram_rdata;
  link_t               lk [DIMS+1];
  logic [IN_W-1:0]     in_c [3];

  assign in_mode  = mode_t'(in_ch.mode);
  assign accept   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);
  assign in_c[0] = in_ch.coord_x;
  assign in_c[1] = in_ch.coord_y;
  assign in_c[2] = in_ch.coord_z;

  // Incoming coordinates, one per axis.
  always_comb begin
    for (int k = 0; k < DIMS; k++) begin
      in_pt[k] = coord_t'(in_c[k]);
    end
  end

  // Checks on a command against the current table.
  always_comb begin
    stat_next = ST_OK;
    unique case (in_mode)
      OP_APPEND: if (held == HELD_W'(CAPACITY)) stat_next = ST_FULL;
      OP_DROP:   if (held == '0) stat_next = ST_EMPTY;
      OP_UNDO:   if (!saved_vld || (HELD_W'(saved_idx) >= held)) stat_next = ST_BAD;
      default: begin
        if (held == '0) begin
          stat_next = ST_EMPTY;
        end else if ((HELD_W'(in_ch.index_a) >= held) ||
                     ((in_mode == OP_DIST) && (HELD_W'(in_ch.index_b) >= held))) begin
          stat_next = ST_BAD;
        end
      end
    endcase
  end

  // RAM port control.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wp;
    ram_wdata = ram_rdata;
    ram_raddr = ADDR_W'(ptr);
    if (accept && (stat_next == ST_OK)) begin
      case (in_mode)
        OP_APPEND: begin
          ram_we    = 1'b1;
          ram_waddr = ADDR_W'(held);
          ram_wdata = in_pt;
        end
        OP_MOVE: begin
          ram_we    = 1'b1;
          ram_waddr = ADDR_W'(in_ch.index_a);
          ram_wdata = in_pt;
        end
        OP_UNDO: begin
          ram_we    = 1'b1;
          ram_waddr = ADDR_W'(saved_idx);
          ram_wdata = saved_pt;
        end
        default: ram_raddr = ADDR_W'(in_ch.index_a);
      endcase
    end
    case (state)
      S_SAVE: begin
        ram_we    = 1'b1;
        ram_waddr = ADDR_W'(ia);
        ram_wdata = pt_r;
      end
      S_SHIFT: ram_we = pend;
      S_LOADC: ram_raddr = ADDR_W'(ia);
      S_STREAM: if (op == OP_DIST) ram_raddr = ADDR_W'(ib);
      default: ;
    endcase
  end

  ptrc_ram #(.DEPTH(CAPACITY), .WIDTH(PT_W)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Distance chain, one cell per axis.
  always_comb begin
    lk[0].vld  = feed_vld;
    lk[0].cnt  = feed_cnt;
    lk[0].last = feed_last;
    lk[0].sum  = '0;
    lk[0].pt   = ram_rdata;
  end

  for (genvar g = 0; g < DIMS; g++) begin : g_cell
    ptrc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .toroidal (toroidal),
      .period   (period[g]),
      .centre   (centre[g]),
      .lk_in    (lk[g]),
      .lk_out   (lk[g+1])
    );
  end

  // Sequencer, table state, registers and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      held      <= '0;
      saved_idx <= '0;
      saved_pt  <= '0;
      saved_vld <= 1'b0;
      toroidal  <= 1'b0;
      period[0] <= '1;
      period[1] <= '1;
      period[2] <= '1;
      pend      <= 1'b0;
      cpend     <= 1'b0;
      feed_vld  <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TOROIDAL: toroidal  <= cfg_data[0];
          CFG_PERIOD_X: period[0] <= cfg_data;
          CFG_PERIOD_Y: period[1] <= cfg_data;
          CFG_PERIOD_Z: period[2] <= cfg_data;
        endcase
      end

      // A taken result is cleared unless a new one is loaded in the same cycle.
      if (out_ch.valid && out_ch.ready && (state != S_DONE)) begin
        out_ch.valid <= 1'b0;
      end

      // One point enters the chain in every streaming cycle.
      feed_vld <= (state == S_STREAM);

      // Results leaving the chain.
      if (lk[DIMS].vld && lk[DIMS].cnt && (lk[DIMS].sum < rsq)) begin
        count <= count + 1'b1;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op    <= in_mode;
            ia    <= in_ch.index_a;
            ib    <= in_ch.index_b;
            pt_r  <= in_pt;
            rsq   <= in_ch.radius_sq;
            stat  <= stat_next;
            count <= '0;
            dist_val <= '0;
            ptr   <= HELD_W'(in_ch.index_a) + 1'b1;
            pend  <= 1'b0;
            state <= S_DONE;
            if (stat_next == ST_OK) begin
              case (in_mode)
                OP_APPEND: held <= held + 1'b1;
                OP_DROP:   held <= held - 1'b1;
                OP_MSAVE:  state <= S_SAVE;
                OP_REMOVE: state <= S_SHIFT;
                OP_COUNT, OP_DIST: state <= S_LOADC;
                default: ;
              endcase
            end
          end
        end
        S_SAVE: begin
          saved_idx <= ia;
          saved_pt  <= ram_rdata;
          saved_vld <= 1'b1;
          state     <= S_DONE;
        end
        S_SHIFT: begin
          // Read point k+1 and write it to k on the next cycle.
          if (ptr < held) begin
            pend <= 1'b1;
            wp   <= ADDR_W'(ptr - 1'b1);
            ptr  <= ptr + 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              held  <= held - 1'b1;
              state <= S_DONE;
            end
          end
        end
        S_LOADC: begin
          cpend <= 1'b1;
          ptr   <= '0;
          state <= S_STREAM;
        end
        S_STREAM: begin
          if (cpend) begin
            centre <= ram_rdata;
            cpend  <= 1'b0;
          end
          if (op == OP_DIST) begin
            feed_cnt  <= 1'b1;
            feed_last <= 1'b1;
            state     <= S_DRAIN;
          end else begin
            feed_cnt  <= (ptr != HELD_W'(ia));
            feed_last <= (ptr == held - 1'b1);
            ptr       <= ptr + 1'b1;
            if (ptr == held - 1'b1) begin
              state <= S_DRAIN;
            end
          end
        end
        S_DRAIN: begin
          if (lk[DIMS].vld && lk[DIMS].last) begin
            dist_val <= lk[DIMS].sum;
            state    <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid           <= 1'b1;
            out_ch.neighbour_count <= ((op == OP_COUNT) && (stat == ST_OK)) ? count : '0;
            out_ch.dist_sq         <= ((op == OP_DIST) && (stat == ST_OK)) ? dist_val : '0;
            out_ch.point_count     <= CNT_W'(held);
            out_ch.status          <= stat;
            state                  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
